FILE: design/swm_pkg.sv
// Shared definitions for the sliding window median unit.
// Holds the register map, parameter defaults and the cell control bundle.
// No dependencies.
package swm_pkg;

   // Parameter defaults
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   // Register map: one 32-bit register per word, byte addresses 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;

   // Window size register
   localparam int WINDOW_SIZE_W = 7;
   localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd3;

   // Control bundle broadcast from the top level to every cell
   typedef struct packed {
      logic update;    // load the next value and age this cycle
      logic insert;    // a new sample joins the window, every entry ages
      logic force_le;  // no insertion: treat every entry as below the sample
      logic del_en;    // remove the oldest entry
   } swm_ctrl_type;

endpackage

FILE: design/swm_csr.sv
// Configuration register block of the sliding window median unit.
// APB-style write/read of the window size register; uses swm_pkg.
module swm_csr
   import swm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready,
   output logic [WINDOW_SIZE_W-1:0] window_size
);

   logic [WINDOW_SIZE_W-1:0] window_size_ff;
   logic [WINDOW_SIZE_W-1:0] window_size_in;
   logic [CSR_IDX_W-1:0]     reg_idx;
   logic                     wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Take the write data on the access cycle of a write transaction
   always_comb begin
      window_size_in = window_size_ff;
      if (wr_en && (reg_idx == REG_WINDOW_SIZE)) begin
         window_size_in = csr_pwdata[WINDOW_SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_WINDOW_SIZE) begin
         csr_prdata = CSR_DATA_W'(window_size_ff);
      end
   end

   assign window_size = window_size_ff;

endmodule

FILE: design/swm_cell.sv
// One cell of the sorted window: holds a sample and its age.
// Compares against the new sample and takes its next entry from itself,
// a neighbour or the new sample; uses swm_pkg.
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int AGE_W       = 6,
   parameter int CNT_W       = 7,
   parameter int IDX         = 0
) (
   input  logic                   clock,
   input  swm_ctrl_type           ctrl,
   input  logic [CNT_W-1:0]       fill,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   prev_le,
   input  logic                   prev_dp,
   input  logic [SAMPLE_BITS-1:0] prev_val,
   input  logic [AGE_W-1:0]       prev_age,
   input  logic                   next_le,
   input  logic [SAMPLE_BITS-1:0] next_val,
   input  logic [AGE_W-1:0]       next_age,
   output logic                   le,
   output logic                   dp,
   output logic [SAMPLE_BITS-1:0] val,
   output logic [AGE_W-1:0]       age
);

   logic [SAMPLE_BITS-1:0] val_ff;
   logic [SAMPLE_BITS-1:0] val_in;
   logic [AGE_W-1:0]       age_ff;
   logic [AGE_W-1:0]       age_in;
   logic [AGE_W-1:0]       sel_age;
   logic [AGE_W-1:0]       oldest_age;
   logic                   valid;
   logic                   is_oldest;
   logic                   take_new;

   assign valid      = CNT_W'(IDX) < fill;
   assign oldest_age = AGE_W'(fill - CNT_W'(1));

   // Entry sorts at or below the new sample (equal values stay older-first)
   assign le = ctrl.force_le ||
               (valid && ($signed(val_ff) <= $signed(sample)));

   // Mark the oldest entry and everything above it for a shift down
   assign is_oldest = ctrl.del_en && valid && (age_ff == oldest_age);
   assign dp        = prev_dp || is_oldest;

   // Pick the next entry: keep, take from a neighbour, or take the new sample
   always_comb begin
      take_new = 1'b0;
      val_in   = val_ff;
      sel_age  = age_ff;
      if (le) begin
         if (dp) begin
            if (next_le) begin
               val_in  = next_val;
               sel_age = next_age;
            end else begin
               take_new = 1'b1;
            end
         end
      end else begin
         if (!prev_dp) begin
            if (prev_le) begin
               take_new = 1'b1;
            end else begin
               val_in  = prev_val;
               sel_age = prev_age;
            end
         end
      end
      if (take_new) begin
         val_in = sample;
         age_in = '0;
      end else if (ctrl.insert) begin
         age_in = sel_age + AGE_W'(1);
      end else begin
         age_in = sel_age;
      end
   end

   // Hold the entry unless the window moves this cycle
   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule

FILE: design/sliding_window_median_unit.sv
// Sliding window median unit: a row of sorted cells gives, for every sample
// once the window holds window_size samples, the lower median of the window
// (the entry at zero-based rank (window_size-1)/2, signed order), then
// drops the oldest sample. One sample is taken every clock while each median
// is taken as soon as it is offered; a median left waiting holds the input
// off until its transaction completes. A result is loaded into the output
// register on the clock edge that takes its sample. A sample
// with tlast set empties the window after it. A window_size of 0 acts as 1
// and one above MAX_WINDOW as MAX_WINDOW. After window_size is lowered, the
// input is held off while each stored sample beyond window_size-1 is
// removed, oldest first, one per cycle. Depends on swm_pkg,
// swm_csr and swm_cell.
module sliding_window_median_unit
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                  req_tlast,   // last_sample
   // Median stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // [SAMPLE_BITS-1:0] median
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int IDX_W = AGE_W;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (CNT_W > WINDOW_SIZE_W) ? CNT_W : WINDOW_SIZE_W;

   logic [WINDOW_SIZE_W-1:0] window_size;
   logic [CMP_W-1:0]         ws_wide;
   logic [CNT_W-1:0]         win_len;
   logic [CNT_W-1:0]         win_len_m1;
   logic [IDX_W-1:0]         mid;
   logic [IDX_W-1:0]         mid_prev;

   logic [CNT_W-1:0]         fill_ff;
   logic [CNT_W-1:0]         fill_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [SAMPLE_BITS-1:0]   median_ff;
   logic [SAMPLE_BITS-1:0]   median_in;

   logic [SAMPLE_BITS-1:0]   sample;
   logic                     trim;
   logic                     accept;
   logic                     produce;
   logic                     below_ok;
   swm_ctrl_type             ctrl;

   logic                     le_w  [MAX_WINDOW];
   logic                     dp_w  [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]   val_w [MAX_WINDOW];
   logic [AGE_W-1:0]         age_w [MAX_WINDOW];

   swm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .window_size (window_size)
   );

   // Clamp the window length to 1..MAX_WINDOW
   assign ws_wide = CMP_W'(window_size);
   always_comb begin
      priority if (ws_wide == '0) begin
         win_len = CNT_W'(1);
      end else if (ws_wide > CMP_W'(MAX_WINDOW)) begin
         win_len = CNT_W'(MAX_WINDOW);
      end else begin
         win_len = CNT_W'(ws_wide);
      end
   end
   assign win_len_m1 = win_len - CNT_W'(1);
   assign mid        = IDX_W'(win_len_m1 >> 1);
   assign mid_prev   = mid - IDX_W'(1);

   // Handshake and cell control
   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign trim       = fill_ff > win_len_m1;
   assign req_tready = !trim && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign produce    = accept && (fill_ff == win_len_m1);

   assign ctrl.update   = accept || trim;
   assign ctrl.insert   = accept;
   assign ctrl.force_le = !accept;
   assign ctrl.del_en   = produce || trim;

   // Row of cells, each wired to its neighbours
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic                   p_le;
      logic                   p_dp;
      logic [SAMPLE_BITS-1:0] p_val;
      logic [AGE_W-1:0]       p_age;
      logic                   n_le;
      logic [SAMPLE_BITS-1:0] n_val;
      logic [AGE_W-1:0]       n_age;

      if (i == 0) begin : g_first
         assign p_le  = 1'b1;
         assign p_dp  = 1'b0;
         assign p_val = sample;
         assign p_age = '0;
      end else begin : g_inner_p
         assign p_le  = le_w[i-1];
         assign p_dp  = dp_w[i-1];
         assign p_val = val_w[i-1];
         assign p_age = age_w[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign n_le  = 1'b0;
         assign n_val = sample;
         assign n_age = '0;
      end else begin : g_inner_n
         assign n_le  = le_w[i+1];
         assign n_val = val_w[i+1];
         assign n_age = age_w[i+1];
      end

      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_W       (AGE_W),
         .CNT_W       (CNT_W),
         .IDX         (i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .fill     (fill_ff),
         .sample   (sample),
         .prev_le  (p_le),
         .prev_dp  (p_dp),
         .prev_val (p_val),
         .prev_age (p_age),
         .next_le  (n_le),
         .next_val (n_val),
         .next_age (n_age),
         .le       (le_w[i]),
         .dp       (dp_w[i]),
         .val      (val_w[i]),
         .age      (age_w[i])
      );
   end

   // Pick the entry at the median rank of the window with the new sample in
   assign below_ok = (mid == '0) || le_w[mid_prev];
   always_comb begin
      if (le_w[mid]) begin
         median_in = val_w[mid];
      end else if (below_ok) begin
         median_in = sample;
      end else begin
         median_in = val_w[mid_prev];
      end
   end

   // Advance the fill count
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         priority if (req_tlast) begin
            fill_in = '0;
         end else if (!produce) begin
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            fill_in = fill_ff;
         end
      end else if (trim) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   // Output register: load on a result, drop once the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         median_ff <= median_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(median_ff);

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_WINDOW))
      else $error("fill count beyond window capacity");

   a_trim_blocks: assert property (@(posedge clock) disable iff (reset)
      trim |-> !req_tready)
      else $error("sample taken while trimming the window");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_tvalid)
      else $error("median not presented after a full window");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (fill_ff == '0))
      else $error("window not cleared after last sample");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("sample taken while a median is stalled");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_median_unit: a scripted pass, then random streams.
// Depends on swm_pkg and the unit's RTL; each median is checked against an arrival-order model or a scripted value.
module testbench
   import swm_pkg::*;
;

   localparam int WINDOW_CAP   = 64;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_TICKS = 4;

   typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;    // sample, or window_size for a register row
      bit           last;
      bit           typed;    // median below is known by inspection
      int           median;
   } script_row_type;

   // Scripted rows: extremes, ties, short streams, zero and shrinking windows
   script_row_type script [28] = '{
      '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 0,            1'b0, 1'b1, 0},
      '{ROW_SAMPLE, -1,           1'b0, 1'b1, -1},
      '{ROW_SAMPLE, 5,            1'b1, 1'b1, 0},
      '{ROW_SAMPLE, 7,            1'b1, 1'b0, 0},   // last sample, window not full
      '{ROW_SAMPLE, 9,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 9,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 9,            1'b0, 1'b1, 9},
      '{ROW_WINDOW, 1,            1'b0, 1'b0, 0},   // shrink with two held
      '{ROW_SAMPLE, -42,          1'b0, 1'b1, -42},
      '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF},
      '{ROW_WINDOW, 0,            1'b0, 1'b0, 0},   // zero acts as one
      '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 32'h80000000},
      '{ROW_SAMPLE, 17,           1'b0, 1'b1, 17},
      '{ROW_WINDOW, 2,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 10,           1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 20,           1'b0, 1'b1, 10},
      '{ROW_SAMPLE, 30,           1'b0, 1'b1, 20},
      '{ROW_SAMPLE, 5,            1'b1, 1'b1, 5},
      '{ROW_WINDOW, 4,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 1,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 2,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 3,            1'b0, 1'b0, 0},
      '{ROW_SAMPLE, 4,            1'b0, 1'b1, 2},
      '{ROW_SAMPLE, 0,            1'b0, 1'b1, 2},
      '{ROW_WINDOW, 2,            1'b0, 1'b0, 0},   // shrink with three held
      '{ROW_SAMPLE, 100,          1'b0, 1'b1, 0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;    // [31:0] sample
   logic                  req_tlast = 1'b0;  // last_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // [31:0] median
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          arrivals[$];         // held samples, oldest first
   int          expected_medians[$];
   int          window_setting = WINDOW_SIZE_RESET;
   int          errors = 0;
   int          idle_cycles = 0;
   logic [31:0] want_median;

   sliding_window_median_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
   endtask

   // Advance the window by one sample; give the lower median once it is full
   function automatic void predict_median(input int sample, input bit last,
                                          output bit produced, output int median);
      int span, rank, below, not_above, i, j;
      span = window_setting;
      if (span == 0) span = 1;
      if (span > WINDOW_CAP) span = WINDOW_CAP;
      while (arrivals.size() > span - 1) void'(arrivals.pop_front());
      arrivals.insert(arrivals.size(), sample);
      produced = 1'b0;
      median   = 0;
      if (arrivals.size() == span) begin
         rank = (span - 1) / 2;
         for (i = 0; i < span; i++) begin
            below     = 0;
            not_above = 0;
            for (j = 0; j < span; j++) begin
               if (arrivals[j] < arrivals[i]) below++;
               if (arrivals[j] <= arrivals[i]) not_above++;
            end
            if (below <= rank && rank < not_above) median = arrivals[i];
         end
         produced = 1'b1;
         void'(arrivals.pop_front());
      end
      if (last) arrivals.delete();
   endfunction

   function automatic int draw_sample();
      unique case ($urandom_range(0, 9))
         0: return int'(32'h80000000);
         1: return int'(32'h7FFFFFFF);
         2: return 0;
         3: return -1;
         4, 5: return int'($urandom_range(0, 16)) - 8;
         default: return int'($urandom);
      endcase
   endfunction

   // Offer one sample after a drawn gap, hold it until taken, then predict
   task automatic send_sample(input int sample, input bit last, input bit typed,
                              input int median, input bit quiet);
      int gap, predicted;
      bit produced;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_median(sample, last, produced, predicted);
      if (produced)
         expected_medians.insert(expected_medians.size(), typed ? median : predicted);
   endtask

   // Hold the input until every expected median has come, then let the unit settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_medians.size() > 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic apb_transfer(input bit write, input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {REG_WINDOW_SIZE, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write window_size while the unit is idle, then read it back
   task automatic set_window(input int size);
      logic [CSR_DATA_W-1:0] readback;
      wait_idle();
      apb_transfer(1'b1, size, readback);
      window_setting = size;
      @(posedge clock);
      apb_transfer(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(size))
         report($sformatf("window_size read %0d, wrote %0d", readback, size));
   endtask

   // Receiver: drawn stalls, with calm stretches of no stalling
   initial begin : receiver
      int stall, calm_left;
      calm_left = 0;
      @(negedge reset);
      forever begin
         if (calm_left > 0) begin
            stall = 0;
            calm_left--;
         end else begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each median transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_medians.size() == 0) begin
            report($sformatf("median %h with none expected", rsp_tdata));
         end else begin
            want_median = expected_medians.pop_front();
            if (rsp_tdata !== want_median)
               report($sformatf("median %h, expected %h", rsp_tdata, want_median));
         end
      end
   end

   // Watchdog: end the run after too long without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: scripted rows, then random streams over a range of window sizes
   initial begin : stimulus
      int phase_windows[10];
      int phase_items, row, n, size;
      bit quiet, last;
      phase_windows = '{64, 127, 5, 1, 7, 2, 0, 3, 0, 0};
      phase_windows[8] = $urandom_range(1, 12);
      phase_windows[9] = $urandom_range(1, 12);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < $size(script); row++) begin
         if (script[row].kind == ROW_WINDOW)
            set_window(script[row].value);
         else
            send_sample(script[row].value, script[row].last, script[row].typed,
                        script[row].median, 1'b0);
      end

      for (row = 0; row < 10; row++) begin
         size = phase_windows[row];
         set_window(size);
         phase_items = (row == 0) ? 110 : (row == 1) ? 90 : 32;
         quiet = ($urandom_range(0, 3) == 0);
         for (n = 0; n < phase_items; n++) begin
            if (size > 32) last = ($urandom_range(0, 99) == 0);
            else last = ($urandom_range(0, 11) == 0);
            send_sample(draw_sample(), last, 1'b0, 0, quiet);
            // Pause the sender mid-stream until the output has drained
            if (n == phase_items / 2 && row == 2) wait_idle();
         end
      end

      wait_idle();
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sliding_window_median_unit.f
design/swm_pkg.sv
design/swm_csr.sv
design/swm_cell.sv
design/sliding_window_median_unit.sv
dv/testbench.sv
